// ===== design/bb3_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helper function of the 3x3 box blur.
package bb3_pkg;

  localparam int CHAN_W      = 8;
  localparam int FW_W        = 10;
  localparam int FH_W        = 13;
  localparam int CFG_DATA_W  = 13;
  localparam int CFG_IDX_W   = 1;
  localparam int OUT_COL_W   = 9;
  localparam int OUT_ROW_W   = 12;
  localparam int SUM_W       = 12;
  localparam int QUEUE_DEPTH = 4;

  // Reciprocal of nine in 16 fractional bits, rounded up; exact for sums below 2296.
  localparam int DIV9_SHIFT      = 16;
  localparam int DIV9_RECIP_W    = 13;
  localparam logic [DIV9_RECIP_W-1:0] DIV9_RECIP = 13'd7282;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [CHAN_W-1:0] a;
    logic [CHAN_W-1:0] r;
    logic [CHAN_W-1:0] g;
    logic [CHAN_W-1:0] b;
  } argb_t;

  typedef struct packed {
    logic interior;
    logic border;
  } cls_t;

  function automatic logic [CHAN_W-1:0] div9(input logic [SUM_W-1:0] s);
    logic [SUM_W+DIV9_RECIP_W-1:0] p;
    p = (SUM_W+DIV9_RECIP_W)'(s) * (SUM_W+DIV9_RECIP_W)'(DIV9_RECIP);
    return p[DIV9_SHIFT+CHAN_W-1:DIV9_SHIFT];
  endfunction

endpackage

// ===== design/bb3_front.sv =====
`timescale 1ns / 1ps
// Front end: frame size registers, position counters, pixel classification and line stores.
module bb3_front import bb3_pkg::*; #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 4096,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int RW = $clog2(MAX_HEIGHT),
  localparam int QW = 2 + RW + CW + 3 * $bits(argb_t)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  argb_t                 in_px,
  output logic                  push_valid,
  input  logic                  push_ready,
  output logic [QW-1:0]         push_data
);

  localparam int WidthRst  = (400 > MAX_WIDTH) ? MAX_WIDTH : 400;
  localparam int HeightRst = (400 > MAX_HEIGHT) ? MAX_HEIGHT : 400;

  logic [CW-1:0] wl_r, wl_nxt;
  logic [RW-1:0] hl_r, hl_nxt;
  logic [CW-1:0] cnt_x_r, cnt_x_nxt;
  logic [RW-1:0] cnt_y_r, cnt_y_nxt;
  logic          s1_v_r, s1_v_nxt;
  logic          pend_v_r;
  logic [CW-1:0] s1_x_r;
  logic [RW-1:0] s1_y_r;
  argb_t         s1_px_r;
  cls_t          s1_cls_r;
  cls_t          cls;
  argb_t         p_rd_r, p2_rd_r, fwd_data_r, up2;
  logic          fwd_hit_r;
  logic          acc;
  logic          cfg_wr;
  logic [FW_W-1:0] fw;
  logic [FH_W-1:0] fh;

  argb_t prev_mem  [MAX_WIDTH];
  argb_t prev2_mem [MAX_WIDTH];

  assign cfg_ready  = 1'b1;
  assign cfg_wr     = cfg_valid && cfg_ready;
  assign fw         = cfg_wdata[FW_W-1:0];
  assign fh         = cfg_wdata[FH_W-1:0];
  assign in_ready   = !s1_v_r || push_ready;
  assign acc        = in_valid && in_ready;
  assign push_valid = s1_v_r;

  // Sizes are kept as last index: zero means one, oversize saturates.
  always_comb begin
    wl_nxt = wl_r;
    hl_nxt = hl_r;
    if (cfg_wr) begin
      case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH: begin
          if (fw == '0) wl_nxt = '0;
          else if (32'(fw) > MAX_WIDTH) wl_nxt = CW'(MAX_WIDTH - 1);
          else wl_nxt = CW'(fw - 1'b1);
        end
        REG_FRAME_HEIGHT: begin
          if (fh == '0) hl_nxt = '0;
          else if (32'(fh) > MAX_HEIGHT) hl_nxt = RW'(MAX_HEIGHT - 1);
          else hl_nxt = RW'(fh - 1'b1);
        end
        default: begin
          wl_nxt = wl_r;
        end
      endcase
    end
  end

  always_comb begin
    cls.interior = (cnt_x_r >= CW'(2)) && (cnt_y_r >= RW'(2)) &&
                   (cnt_x_r <= wl_r) && (cnt_y_r <= hl_r);
    cls.border   = (cnt_x_r == '0) || (cnt_y_r == '0) ||
                   (cnt_x_r >= wl_r) || (cnt_y_r >= hl_r);
  end

  always_comb begin
    cnt_x_nxt = cnt_x_r;
    cnt_y_nxt = cnt_y_r;
    if (acc) begin
      if (cnt_x_r >= wl_r) begin
        cnt_x_nxt = '0;
        cnt_y_nxt = (cnt_y_r >= hl_r) ? '0 : cnt_y_r + 1'b1;
      end else begin
        cnt_x_nxt = cnt_x_r + 1'b1;
      end
    end
  end

  assign s1_v_nxt = acc || (s1_v_r && !push_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wl_r     <= CW'(WidthRst - 1);
      hl_r     <= RW'(HeightRst - 1);
      cnt_x_r  <= '0;
      cnt_y_r  <= '0;
      s1_v_r   <= 1'b0;
      pend_v_r <= 1'b0;
    end else begin
      wl_r     <= wl_nxt;
      hl_r     <= hl_nxt;
      cnt_x_r  <= cnt_x_nxt;
      cnt_y_r  <= cnt_y_nxt;
      s1_v_r   <= s1_v_nxt;
      pend_v_r <= acc;
    end
  end

  // The row above moves into the second store in the cycle after its read returns.
  always_ff @(posedge clk) begin
    if (acc) begin
      p_rd_r             <= prev_mem[cnt_x_r];
      prev_mem[cnt_x_r]  <= in_px;
      p2_rd_r            <= prev2_mem[cnt_x_r];
      fwd_hit_r          <= pend_v_r && (s1_x_r == cnt_x_r);
      fwd_data_r         <= p_rd_r;
      s1_x_r             <= cnt_x_r;
      s1_y_r             <= cnt_y_r;
      s1_px_r            <= in_px;
      s1_cls_r           <= cls;
    end
    if (pend_v_r) begin
      prev2_mem[s1_x_r]  <= p_rd_r;
    end
  end

  assign up2       = fwd_hit_r ? fwd_data_r : p2_rd_r;
  assign push_data = {s1_cls_r, s1_y_r, s1_x_r, s1_px_r, p_rd_r, up2};

endmodule

// ===== design/bb3_queue.sv =====
`timescale 1ns / 1ps
// Small register queue that decouples the front end from the filter back end.
module bb3_queue import bb3_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);

  localparam int AW = $clog2(QUEUE_DEPTH);

  logic [WIDTH-1:0] slot_r [QUEUE_DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]      count_r, count_nxt;
  logic             push, pop;

  assign wr_ready = (count_r != (AW+1)'(QUEUE_DEPTH));
  assign rd_valid = (count_r != '0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_data  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= wr_data;
  end

endmodule

// ===== design/bb3_back.sv =====
`timescale 1ns / 1ps
// Back end: 3x3 window, channel sums, divide by nine and the result register.
module bb3_back import bb3_pkg::*; #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 4096,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int RW = $clog2(MAX_HEIGHT),
  localparam int QW = 2 + RW + CW + 3 * $bits(argb_t)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  logic [QW-1:0]        q_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [OUT_COL_W-1:0] out_col,
  output logic [OUT_ROW_W-1:0] out_row,
  output logic [CHAN_W-1:0]    out_red,
  output logic [CHAN_W-1:0]    out_green,
  output logic [CHAN_W-1:0]    out_blue,
  output logic [CHAN_W-1:0]    out_alpha,
  output logic                 out_run_end
);

  cls_t          q_cls;
  logic [RW-1:0] q_y;
  logic [CW-1:0] q_x;
  argb_t         q_px, q_up1, q_up2;

  argb_t         win_r [9];
  logic          b1_v_r, b1_v_nxt;
  logic [CW-1:0] b1_x_r;
  logic [RW-1:0] b1_y_r;
  argb_t         b1_px_r;
  cls_t          b1_cls_r;

  logic             b2_v_r, b2_v_nxt;
  logic [CW-1:0]    b2_x_r;
  logic [RW-1:0]    b2_y_r;
  argb_t            b2_px_r;
  cls_t             b2_cls_r;
  logic [SUM_W-1:0] b2_sr_r, b2_sg_r, b2_sb_r;
  logic [CHAN_W-1:0] b2_ca_r;
  logic [SUM_W-1:0] sum_r, sum_g, sum_b;

  logic                 out_v_r, out_v_nxt;
  logic                 sec_v_r, sec_v_nxt;
  logic [OUT_COL_W-1:0] out_col_r, sec_col_r;
  logic [OUT_ROW_W-1:0] out_row_r, sec_row_r;
  argb_t                out_px_r, sec_px_r;
  logic                 out_end_r;

  logic out_free, load_sec, b2_take, b2_fire, b1_take, pop;

  assign {q_cls, q_y, q_x, q_px, q_up1, q_up2} = q_data;

  assign out_free = !out_v_r || out_ready;
  assign load_sec = out_v_r && out_ready && sec_v_r;
  assign b2_take  = !b2_v_r || (out_free && !sec_v_r);
  assign b2_fire  = b2_v_r && out_free && !sec_v_r;
  assign b1_take  = !b1_v_r || b2_take;
  assign q_ready  = b1_take;
  assign pop      = q_valid && b1_take;

  always_comb begin
    sum_r = '0;
    sum_g = '0;
    sum_b = '0;
    for (int k = 0; k < 9; k++) begin
      sum_r = sum_r + SUM_W'(win_r[k].r);
      sum_g = sum_g + SUM_W'(win_r[k].g);
      sum_b = sum_b + SUM_W'(win_r[k].b);
    end
  end

  always_comb begin
    b1_v_nxt  = b1_take ? q_valid : b1_v_r;
    b2_v_nxt  = b2_take ? b1_v_r : b2_v_r;
    out_v_nxt = out_v_r;
    sec_v_nxt = sec_v_r;
    if (b2_fire) begin
      out_v_nxt = b2_cls_r.interior || b2_cls_r.border;
      sec_v_nxt = b2_cls_r.interior && b2_cls_r.border;
    end else if (load_sec) begin
      out_v_nxt = 1'b1;
      sec_v_nxt = 1'b0;
    end else if (out_v_r && out_ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r  <= 1'b0;
      b2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      sec_v_r <= 1'b0;
    end else begin
      b1_v_r  <= b1_v_nxt;
      b2_v_r  <= b2_v_nxt;
      out_v_r <= out_v_nxt;
      sec_v_r <= sec_v_nxt;
    end
  end

  // Window columns run oldest to newest; rows run two above, one above, current.
  always_ff @(posedge clk) begin
    if (pop) begin
      for (int k = 0; k < 3; k++) begin
        win_r[k*3+0] <= win_r[k*3+1];
        win_r[k*3+1] <= win_r[k*3+2];
      end
      win_r[2] <= q_up2;
      win_r[5] <= q_up1;
      win_r[8] <= q_px;
      b1_x_r   <= q_x;
      b1_y_r   <= q_y;
      b1_px_r  <= q_px;
      b1_cls_r <= q_cls;
    end
  end

  always_ff @(posedge clk) begin
    if (b1_v_r && b2_take) begin
      b2_sr_r  <= sum_r;
      b2_sg_r  <= sum_g;
      b2_sb_r  <= sum_b;
      b2_ca_r  <= win_r[4].a;
      b2_x_r   <= b1_x_r;
      b2_y_r   <= b1_y_r;
      b2_px_r  <= b1_px_r;
      b2_cls_r <= b1_cls_r;
    end
  end

  // An item on the border of an interior centre yields the filtered centre first.
  always_ff @(posedge clk) begin
    if (b2_fire) begin
      sec_col_r <= OUT_COL_W'(b2_x_r);
      sec_row_r <= OUT_ROW_W'(b2_y_r);
      sec_px_r  <= b2_px_r;
      if (b2_cls_r.interior) begin
        out_col_r  <= OUT_COL_W'(b2_x_r - 1'b1);
        out_row_r  <= OUT_ROW_W'(b2_y_r - 1'b1);
        out_px_r.a <= b2_ca_r;
        out_px_r.r <= div9(b2_sr_r);
        out_px_r.g <= div9(b2_sg_r);
        out_px_r.b <= div9(b2_sb_r);
        out_end_r  <= !b2_cls_r.border;
      end else begin
        out_col_r  <= OUT_COL_W'(b2_x_r);
        out_row_r  <= OUT_ROW_W'(b2_y_r);
        out_px_r   <= b2_px_r;
        out_end_r  <= 1'b1;
      end
    end else if (load_sec) begin
      out_col_r <= sec_col_r;
      out_row_r <= sec_row_r;
      out_px_r  <= sec_px_r;
      out_end_r <= 1'b1;
    end
  end

  assign out_valid   = out_v_r;
  assign out_col     = out_col_r;
  assign out_row     = out_row_r;
  assign out_red     = out_px_r.r;
  assign out_green   = out_px_r.g;
  assign out_blue    = out_px_r.b;
  assign out_alpha   = out_px_r.a;
  assign out_run_end = out_end_r;

endmodule

// ===== design/box_blur_3x3_filter.sv =====
`timescale 1ns / 1ps
// Items pass the front-end stage, the queue, window and sum stages and the result register.
// Throughput: one item per cycle while out_ready stays high; an item that yields two results
// holds the result register for both; the four-entry queue behind the front end absorbs it.
// Reset (synchronous, rst_n low): counters return to zero, frame size to 400 by 400, all
// pipeline and queue state empties. Line stores are not cleared; no clearing pass is made.
module box_blur_3x3_filter import bb3_pkg::*; #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [CHAN_W-1:0]     in_red,
  input  logic [CHAN_W-1:0]     in_green,
  input  logic [CHAN_W-1:0]     in_blue,
  input  logic [CHAN_W-1:0]     in_alpha,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OUT_COL_W-1:0]  out_col,
  output logic [OUT_ROW_W-1:0]  out_row,
  output logic [CHAN_W-1:0]     out_red,
  output logic [CHAN_W-1:0]     out_green,
  output logic [CHAN_W-1:0]     out_blue,
  output logic [CHAN_W-1:0]     out_alpha,
  output logic                  out_run_end
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int QW = 2 + RW + CW + 3 * $bits(argb_t);

  argb_t         in_px;
  logic          push_valid, push_ready, pop_valid, pop_ready;
  logic [QW-1:0] push_data, pop_data;

  assign in_px = '{a: in_alpha, r: in_red, g: in_green, b: in_blue};

  bb3_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_px     (in_px),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data)
  );

  bb3_queue #(
    .WIDTH(QW)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_valid(push_valid),
    .wr_ready(push_ready),
    .wr_data (push_data),
    .rd_valid(pop_valid),
    .rd_ready(pop_ready),
    .rd_data (pop_data)
  );

  bb3_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (pop_valid),
    .q_ready    (pop_ready),
    .q_data     (pop_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_col    (out_col),
    .out_row    (out_row),
    .out_red    (out_red),
    .out_green  (out_green),
    .out_blue   (out_blue),
    .out_alpha  (out_alpha),
    .out_run_end(out_run_end)
  );

endmodule

// ===== design/bb3_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the box blur, bound to the top level.
module bb3_checker import bb3_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [OUT_COL_W-1:0] out_col,
  input logic [OUT_ROW_W-1:0] out_row,
  input logic [CHAN_W-1:0]    out_red,
  input logic                 out_run_end
);

  // Reset leaves the block empty and ready for the first item.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && in_ready))
    else $error("block not empty after reset");

  // A filtered centre that is not last is followed at once by the border pixel below right.
  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_run_end) |=>
      (out_valid && out_run_end &&
       (out_col == OUT_COL_W'($past(out_col) + 1'b1)) &&
       (out_row == OUT_ROW_W'($past(out_row) + 1'b1))))
    else $error("second result of an item is missing or misplaced");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_col) && $stable(out_row) && $stable(out_red) &&
       $stable(out_run_end)))
    else $error("stalled result changed");

endmodule

bind box_blur_3x3_filter bb3_checker u_bb3_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_col    (out_col),
  .out_row    (out_row),
  .out_red    (out_red),
  .out_run_end(out_run_end)
);

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the 3x3 box blur: random ARGB frames of varied size, with checks.
module tb import bb3_pkg::*; ();

  localparam int FRAME_MAX_W   = 512;
  localparam int FRAME_MAX_H   = 4096;
  localparam int RANDOM_ITEMS  = 1850;
  localparam int SETTLE_CYCLES = 10;

  typedef struct {
    logic [OUT_COL_W-1:0] col;
    logic [OUT_ROW_W-1:0] row;
    logic [CHAN_W-1:0]    red;
    logic [CHAN_W-1:0]    green;
    logic [CHAN_W-1:0]    blue;
    logic [CHAN_W-1:0]    alpha;
    logic                 run_end;
  } blur_px_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [CHAN_W-1:0] in_red = '0;
  logic [CHAN_W-1:0] in_green = '0;
  logic [CHAN_W-1:0] in_blue = '0;
  logic [CHAN_W-1:0] in_alpha = '0;

  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [OUT_COL_W-1:0] out_col;
  logic [OUT_ROW_W-1:0] out_row;
  logic [CHAN_W-1:0]    out_red;
  logic [CHAN_W-1:0]    out_green;
  logic [CHAN_W-1:0]    out_blue;
  logic [CHAN_W-1:0]    out_alpha;
  logic                 out_run_end;

  argb_t    pixels_to_send [$];
  blur_px_t blurred_due [$];
  int       mismatches = 0;
  bit       calm = 1'b0;

  // Shadow of the block: frame size registers, position counters, line stores and window.
  logic [FW_W-1:0] frame_w_reg = FW_W'(400);
  logic [FH_W-1:0] frame_h_reg = FH_W'(400);
  int              col_pos = 0;
  int              row_pos = 0;
  argb_t           line_prev  [FRAME_MAX_W];
  argb_t           line_prev2 [FRAME_MAX_W];
  int              write_cnt  [FRAME_MAX_W] = '{default: 0};
  argb_t           blur_win   [9];

  box_blur_3x3_filter #(
    .MAX_WIDTH  (FRAME_MAX_W),
    .MAX_HEIGHT (FRAME_MAX_H)
  ) i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_red      (in_red),
    .in_green    (in_green),
    .in_blue     (in_blue),
    .in_alpha    (in_alpha),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_col     (out_col),
    .out_row     (out_row),
    .out_red     (out_red),
    .out_green   (out_green),
    .out_blue    (out_blue),
    .out_alpha   (out_alpha),
    .out_run_end (out_run_end)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int clip_size(input int v, input int maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  // Advances the shadow by one pixel and queues the results it must produce.
  function automatic void filter_pixel(input argb_t px);
    int       w, h, x, y, k, sr, sg, sb;
    argb_t    up1, up2;
    bit       inner, on_border;
    blur_px_t res;
    w = clip_size(int'(frame_w_reg), FRAME_MAX_W);
    h = clip_size(int'(frame_h_reg), FRAME_MAX_H);
    x = col_pos;
    y = row_pos;
    up2 = line_prev2[x];
    up1 = line_prev[x];
    line_prev2[x] = up1;
    line_prev[x] = px;
    if (write_cnt[x] < 2) write_cnt[x]++;
    for (k = 0; k < 3; k++) begin
      blur_win[k*3]   = blur_win[k*3+1];
      blur_win[k*3+1] = blur_win[k*3+2];
    end
    blur_win[2] = up2;
    blur_win[5] = up1;
    blur_win[8] = px;
    inner = (x >= 2 && y >= 2 && x <= w - 1 && y <= h - 1);
    on_border = (x == 0 || y == 0 || x >= w - 1 || y >= h - 1);
    if (inner) begin
      sr = 0;
      sg = 0;
      sb = 0;
      for (k = 0; k < 9; k++) begin
        sr += int'(blur_win[k].r);
        sg += int'(blur_win[k].g);
        sb += int'(blur_win[k].b);
      end
      res.col     = OUT_COL_W'(x - 1);
      res.row     = OUT_ROW_W'(y - 1);
      res.red     = CHAN_W'(sr / 9);
      res.green   = CHAN_W'(sg / 9);
      res.blue    = CHAN_W'(sb / 9);
      res.alpha   = blur_win[4].a;
      res.run_end = !on_border;
      blurred_due.push_back(res);
    end
    if (on_border) begin
      res.col     = OUT_COL_W'(x);
      res.row     = OUT_ROW_W'(y);
      res.red     = px.r;
      res.green   = px.g;
      res.blue    = px.b;
      res.alpha   = px.a;
      res.run_end = 1'b1;
      blurred_due.push_back(res);
    end
    x++;
    if (x >= w) begin
      x = 0;
      y++;
      if (y >= h) y = 0;
    end
    col_pos = x;
    row_pos = y;
  endfunction

  // Pixels still to come before the position counters return to the frame origin.
  function automatic int frame_left();
    int w, h, n;
    w = clip_size(int'(frame_w_reg), FRAME_MAX_W);
    h = clip_size(int'(frame_h_reg), FRAME_MAX_H);
    n = (col_pos >= w) ? 1 : w - col_pos;
    if (row_pos + 1 < h) n += (h - row_pos - 1) * w;
    return n;
  endfunction

  // A width change in mid-frame is allowed only if no later interior window can pick up a
  // line store entry that was never written since reset.
  function automatic bit resize_safe(input int w_new);
    int x;
    bit ok;
    ok = 1'b1;
    for (x = 0; x < w_new; x++) begin
      if (row_pos >= 2 && x >= col_pos && write_cnt[x] < 2) ok = 1'b0;
      if (row_pos >= 1 && x < col_pos && write_cnt[x] < 2) ok = 1'b0;
      if (row_pos >= 1 && x >= col_pos && write_cnt[x] < 1) ok = 1'b0;
    end
    return ok;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_width();
    int sel, v;
    sel = $urandom_range(99);
    if (sel < 70) v = $urandom_range(3, 10);
    else if (sel < 80) v = $urandom_range(0, 2);
    else if (sel < 92) v = $urandom_range(11, 48);
    else if (sel < 96) v = FRAME_MAX_W;
    else v = $urandom_range(FRAME_MAX_W + 1, 1023);
    // The upper bits lie outside the width register and must be ignored.
    return {3'($urandom_range(7)), 10'(v)};
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_height();
    int sel, v;
    sel = $urandom_range(99);
    if (sel < 70) v = $urandom_range(3, 8);
    else if (sel < 82) v = $urandom_range(0, 2);
    else if (sel < 94) v = $urandom_range(9, 24);
    else if (sel < 97) v = FRAME_MAX_H;
    else v = $urandom_range(FRAME_MAX_H + 1, 8191);
    return CFG_DATA_W'(v);
  endfunction

  function automatic void check_field(input string name, input logic [11:0] want,
                                      input logic [11:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  task automatic set_frame(input bit put_w, input logic [CFG_DATA_W-1:0] wval,
                           input bit put_h, input logic [CFG_DATA_W-1:0] hval);
    if (put_w) begin
      cfg_valid <= 1'b1;
      cfg_index <= REG_FRAME_WIDTH;
      cfg_wdata <= wval;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      frame_w_reg = wval[FW_W-1:0];
    end
    if (put_h) begin
      cfg_valid <= 1'b1;
      cfg_index <= REG_FRAME_HEIGHT;
      cfg_wdata <= hval;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      frame_h_reg = hval[FH_W-1:0];
    end
    cfg_valid <= 1'b0;
  endtask

  // Waits until every pixel is taken and every result has come, then lets the pipe drain.
  task automatic settle();
    while (pixels_to_send.size() != 0 || blurred_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin : pixel_drive
    bit took;
    took = in_valid && in_ready;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (took) filter_pixel(pixels_to_send.pop_front());
      if (in_valid && !took) begin
        // Hold the item until the block takes it.
      end else if (pixels_to_send.size() != 0 && (calm || $urandom_range(99) >= 7)) begin
        in_valid <= 1'b1;
        in_red   <= pixels_to_send[0].r;
        in_green <= pixels_to_send[0].g;
        in_blue  <= pixels_to_send[0].b;
        in_alpha <= pixels_to_send[0].a;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : result_check
    blur_px_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (blurred_due.size() == 0) begin
          $error("result at col %0d row %0d with nothing expected", out_col, out_row);
          mismatches++;
        end else begin
          want = blurred_due.pop_front();
          check_field("out_col", 12'(want.col), 12'(out_col));
          check_field("out_row", want.row, out_row);
          check_field("out_red", 12'(want.red), 12'(out_red));
          check_field("out_green", 12'(want.green), 12'(out_green));
          check_field("out_blue", 12'(want.blue), 12'(out_blue));
          check_field("out_alpha", 12'(want.alpha), 12'(out_alpha));
          check_field("out_run_end", 12'(want.run_end), 12'(out_run_end));
        end
      end
      out_ready <= calm || ($urandom_range(99) >= 7);
    end
  end

  initial begin : stimulus
    int                    i, n, sel, random_sent;
    bit                    put_w, put_h;
    logic [CFG_DATA_W-1:0] wdata, hdata;
    random_sent = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset size is 400 by 400, so the start of the first row passes straight through.
    pixels_to_send.push_back(argb_t'(32'h0000_0000));
    pixels_to_send.push_back(argb_t'(32'hFFFF_FFFF));
    pixels_to_send.push_back(argb_t'(32'hA55A_3CC3));
    settle();

    // Shrink in mid-row: the current column is past the new last one and wraps.
    // Saturated windows check the largest sum, and the last column gives two results.
    set_frame(1'b1, CFG_DATA_W'(3), 1'b1, CFG_DATA_W'(4));
    for (i = 0; i < 10; i++) pixels_to_send.push_back(argb_t'(32'hFFFF_FFFF));
    settle();

    // A zero width acts as one; the set upper bits fall outside the register.
    set_frame(1'b1, CFG_DATA_W'(13'h1C00), 1'b1, CFG_DATA_W'(2));
    for (i = 0; i < 4; i++) pixels_to_send.push_back(argb_t'($urandom));
    settle();

    set_frame(1'b1, CFG_DATA_W'(FRAME_MAX_W), 1'b1, CFG_DATA_W'(FRAME_MAX_H));
    for (i = 0; i < 3; i++) pixels_to_send.push_back(argb_t'($urandom));
    settle();

    // Sizes above the maximum saturate.
    set_frame(1'b1, CFG_DATA_W'(13'h1FFF), 1'b1, CFG_DATA_W'(13'h1FFF));
    for (i = 0; i < 2; i++) pixels_to_send.push_back(argb_t'($urandom));

    while (random_sent < RANDOM_ITEMS) begin
      settle();
      calm = (random_sent >= 700 && random_sent < 1000);
      sel = $urandom_range(9);
      put_w = (sel < 6);
      put_h = (sel < 4 || sel == 6 || sel == 7);
      wdata = pick_width();
      hdata = pick_height();
      if (col_pos != 0 || row_pos != 0) begin
        // Wind a large frame down to a small one.
        if (frame_left() > 300) begin
          put_h = 1'b1;
          hdata = CFG_DATA_W'($urandom_range(1, 3));
          put_w = 1'b1;
          wdata = CFG_DATA_W'($urandom_range(1, 8));
        end
        if (put_w && !resize_safe(clip_size(int'(wdata[FW_W-1:0]), FRAME_MAX_W))) begin
          put_w = 1'b0;
        end
      end
      set_frame(put_w, wdata, put_h, hdata);
      n = frame_left();
      if (n > 300 || $urandom_range(3) == 0) begin
        n = ($urandom_range(9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 40);
      end
      for (i = 0; i < n; i++) pixels_to_send.push_back(argb_t'($urandom));
      random_sent += n;
    end
    calm = 1'b0;
    settle();

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
